FILE: rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, character codes and parse-step functions of the CSV tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] SEP_RESET = 8'h2C;

	// UTF-8 byte-order mark
	localparam logic [7:0] BOM0 = 8'hEF;
	localparam logic [7:0] BOM1 = 8'hBB;
	localparam logic [7:0] BOM2 = 8'hBF;

	// Token kinds
	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_FIELD  = 2'd1;
	localparam logic [1:0] KIND_RECORD = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} cst_in_t;

	typedef struct packed {
		logic [1:0] token_kind;
		logic [7:0] char_value;
		logic       last_of_run;
	} cst_out_t;

	// Byte class, worked out at the front
	typedef struct packed {
		logic [7:0] chr;
		logic       is_nl;
		logic       is_quote;
		logic       is_cr;
		logic       is_bs;
		logic       is_sep;
		logic       esc_ok;
		logic [7:0] esc_val;
	} cst_cls_t;

	// One queued word: the ops one input byte causes
	typedef struct packed {
		logic     rep_ef;
		logic     rep_bb;
		logic     proc;
		logic     fin;
		logic     sep_ef;
		logic     sep_bb;
		cst_cls_t cls;
	} cst_cmd_t;

	// Parse state
	typedef struct packed {
		logic quoting;
		logic qwait;
		logic fnon;
		logic ewait;
		logic skip;
		logic lhb;
	} cst_pst_t;

	typedef struct packed {
		cst_pst_t   st;
		logic       emit;
		logic [1:0] kind;
		logic [7:0] chr;
	} cst_step_t;

	function automatic cst_step_t end_record(cst_step_t r_in);
		cst_step_t r;
		r            = r_in;
		r.emit       = 1'b1;
		r.kind       = KIND_RECORD;
		r.chr        = 8'h00;
		r.st.fnon    = 1'b0;
		r.st.ewait   = 1'b0;
		r.st.quoting = 1'b0;
		r.st.qwait   = 1'b0;
		return r;
	endfunction

	// Append a raw character through escape decoding
	function automatic cst_step_t take_char(cst_step_t r_in, cst_cls_t c);
		cst_step_t r;
		r         = r_in;
		r.st.fnon = 1'b1;
		if (r.st.ewait) begin
			r.st.ewait = 1'b0;
			if (c.esc_ok) begin
				r.emit = 1'b1;
				r.kind = KIND_CHAR;
				r.chr  = c.esc_val;
			end
		end else if (c.is_bs) begin
			r.st.ewait = 1'b1;
		end else begin
			r.emit = 1'b1;
			r.kind = KIND_CHAR;
			r.chr  = c.chr;
		end
		return r;
	endfunction

	// One nonzero data byte
	function automatic cst_step_t proc_byte(cst_pst_t st, cst_cls_t c);
		cst_step_t r;
		logic      cont;
		r.st   = st;
		r.emit = 1'b0;
		r.kind = KIND_CHAR;
		r.chr  = 8'h00;
		cont   = 1'b1;
		if (c.is_nl) begin
			if (!st.skip) begin
				r = end_record(r);
			end
			r.st.fnon    = 1'b0;
			r.st.ewait   = 1'b0;
			r.st.quoting = 1'b0;
			r.st.qwait   = 1'b0;
			r.st.skip    = 1'b0;
			r.st.lhb     = 1'b0;
		end else begin
			r.st.lhb = 1'b1;
			if (!st.skip) begin
				if (r.st.qwait) begin
					r.st.qwait = 1'b0;
					if (c.is_quote) begin
						r    = take_char(r, c);
						cont = 1'b0;
					end else begin
						r.st.quoting = 1'b0;
					end
				end
				if (cont) begin
					priority if (!r.st.quoting && !r.st.fnon && c.is_quote) begin
						r.st.quoting = 1'b1;
					end else if (r.st.quoting && c.is_quote) begin
						r.st.qwait = 1'b1;
					end else if (!r.st.quoting && c.is_sep) begin
						r.emit     = 1'b1;
						r.kind     = KIND_FIELD;
						r.chr      = 8'h00;
						r.st.fnon  = 1'b0;
						r.st.ewait = 1'b0;
					end else if (!r.st.quoting && c.is_cr) begin
						r         = end_record(r);
						r.st.skip = 1'b1;
					end else begin
						r = take_char(r, c);
					end
				end
			end
		end
		return r;
	endfunction

	// End of data: close an open line
	function automatic cst_step_t finish(cst_pst_t st);
		cst_step_t r;
		r.st   = st;
		r.emit = 1'b0;
		r.kind = KIND_CHAR;
		r.chr  = 8'h00;
		if (st.lhb && !st.skip) begin
			r = end_record(r);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front
// Byte intake: byte-order-mark check, separator register and byte classing.
// ----------------------------------------------------------------------------
module cst_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cst_pkg::cst_in_t  in_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data,
	output logic              q_push,
	output cst_pkg::cst_cmd_t q_data,
	input  logic              q_full
);
	import cst_pkg::*;

	localparam logic [1:0] MP_CHECK = 2'd0;
	localparam logic [1:0] MP_EF    = 2'd1;
	localparam logic [1:0] MP_EFBB  = 2'd2;
	localparam logic [1:0] MP_DONE  = 2'd3;

	logic [1:0] mark_q;
	logic [1:0] mark_m;
	logic [1:0] mark_nxt;
	logic [1:0] rep_src;
	logic [7:0] sep_q;
	logic [7:0] b;
	logic       e;
	logic       matched;
	logic       rep_gate;

	assign in_ready  = !q_full;
	assign q_push    = in_valid && !q_full;
	assign cfg_ready = 1'b1;
	assign b         = in_data.data_byte;
	assign e         = in_data.end_of_data;

	always_comb begin
		matched = 1'b0;
		mark_m  = mark_q;
		priority if (mark_q == MP_CHECK && b == BOM0) begin
			matched = 1'b1;
			mark_m  = MP_EF;
		end else if (mark_q == MP_EF && b == BOM1) begin
			matched = 1'b1;
			mark_m  = MP_EFBB;
		end else if (mark_q == MP_EFBB && b == BOM2) begin
			matched = 1'b1;
			mark_m  = MP_DONE;
		end else begin
			matched = 1'b0;
		end
	end

	// A partial mark replays on a mismatch, or at end of data right after a match
	assign rep_src  = matched ? mark_m : mark_q;
	assign rep_gate = matched ? e : 1'b1;
	assign mark_nxt = (matched && !e) ? mark_m : MP_DONE;

	always_comb begin
		q_data.rep_ef       = rep_gate && (rep_src == MP_EF || rep_src == MP_EFBB);
		q_data.rep_bb       = rep_gate && (rep_src == MP_EFBB);
		q_data.proc         = !matched && (b != CH_NUL);
		q_data.fin          = matched ? e : ((b == CH_NUL) || e);
		q_data.sep_ef       = (sep_q == BOM0);
		q_data.sep_bb       = (sep_q == BOM1);
		q_data.cls.chr      = b;
		q_data.cls.is_nl    = (b == CH_NL);
		q_data.cls.is_quote = (b == CH_QUOTE);
		q_data.cls.is_cr    = (b == CH_CR);
		q_data.cls.is_bs    = (b == CH_BSLASH);
		q_data.cls.is_sep   = (b == sep_q);
		q_data.cls.esc_ok   = 1'b1;
		unique case (b)
			"a":       q_data.cls.esc_val = 8'd7;
			"b":       q_data.cls.esc_val = 8'd8;
			"f":       q_data.cls.esc_val = 8'd12;
			"n":       q_data.cls.esc_val = 8'd10;
			"r":       q_data.cls.esc_val = 8'd13;
			"t":       q_data.cls.esc_val = 8'd9;
			"v":       q_data.cls.esc_val = 8'd11;
			CH_BSLASH: q_data.cls.esc_val = CH_BSLASH;
			default: begin
				q_data.cls.esc_ok  = 1'b0;
				q_data.cls.esc_val = 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= MP_CHECK;
			sep_q  <= SEP_RESET;
		end else begin
			if (q_push) begin
				mark_q <= mark_nxt;
			end
			if (cfg_valid) begin
				sep_q <= cfg_data;
			end
		end
	end

endmodule

FILE: rtl/core/cst_queue.sv
// ----------------------------------------------------------------------------
// cst_queue
// Small register FIFO between intake and parser.
// ----------------------------------------------------------------------------
module cst_queue #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [Width-1:0] head_data
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == CntW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/core/cst_back.sv
// ----------------------------------------------------------------------------
// cst_back
// Parser: runs the queued ops on the parse state, drains tokens one a cycle unless out_ready stalls.
// ----------------------------------------------------------------------------
module cst_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cst_pkg::cst_cmd_t q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output cst_pkg::cst_out_t out_data
);
	import cst_pkg::*;

	cst_pst_t   st_q;
	cst_pst_t   st_nxt;
	logic       halted_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	cst_out_t   out_data_q;

	cst_cls_t   cls_ef;
	cst_cls_t   cls_bb;
	cst_step_t  r_ef;
	cst_step_t  r_bb;
	cst_step_t  r_cur;
	cst_step_t  r_fin;
	cst_pst_t   s1;
	cst_pst_t   s2;
	cst_pst_t   s3;
	cst_pst_t   s4;
	logic [3:0] em;
	cst_step_t  slot [4];
	logic [1:0] tok_kind [4];
	logic [7:0] tok_chr [4];
	logic [2:0] cnt;
	logic       adv;
	logic       last;
	logic       done;

	// Replayed mark bytes carry fixed classes, bar the separator match
	always_comb begin
		cls_ef        = '0;
		cls_ef.chr    = BOM0;
		cls_ef.is_sep = q_data.sep_ef;
		cls_bb        = '0;
		cls_bb.chr    = BOM1;
		cls_bb.is_sep = q_data.sep_bb;
	end

	// Chain the ops of one word on the parse state
	always_comb begin
		r_ef  = proc_byte(st_q, cls_ef);
		s1    = q_data.rep_ef ? r_ef.st : st_q;
		r_bb  = proc_byte(s1, cls_bb);
		s2    = q_data.rep_bb ? r_bb.st : s1;
		r_cur = proc_byte(s2, q_data.cls);
		s3    = q_data.proc ? r_cur.st : s2;
		r_fin = finish(s3);
		s4    = q_data.fin ? r_fin.st : s3;
		em[0] = !halted_q && q_data.rep_ef && r_ef.emit;
		em[1] = !halted_q && q_data.rep_bb && r_bb.emit;
		em[2] = !halted_q && q_data.proc && r_cur.emit;
		em[3] = !halted_q && q_data.fin && r_fin.emit;
		st_nxt = halted_q ? st_q : s4;
	end

	// Pack emitted tokens to the front
	always_comb begin
		slot[0] = r_ef;
		slot[1] = r_bb;
		slot[2] = r_cur;
		slot[3] = r_fin;
		cnt     = 3'd0;
		for (int i = 0; i < 4; i++) begin
			tok_kind[i] = KIND_CHAR;
			tok_chr[i]  = 8'h00;
		end
		for (int i = 0; i < 4; i++) begin
			if (em[i]) begin
				tok_kind[cnt[1:0]] = slot[i].kind;
				tok_chr[cnt[1:0]]  = slot[i].chr;
				cnt                = cnt + 3'd1;
			end
		end
	end

	assign adv       = q_valid && (!out_valid_q || out_ready);
	assign last      = ({1'b0, idx_q} == (cnt - 3'd1));
	assign done      = (cnt == 3'd0) || last;
	assign q_pop     = adv && done;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			halted_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv && cnt != 3'd0) begin
				out_valid_q <= 1'b1;
			end
			if (adv) begin
				if (done) begin
					st_q     <= st_nxt;
					halted_q <= halted_q || q_data.fin;
					idx_q    <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cnt != 3'd0) begin
			out_data_q.token_kind  <= tok_kind[idx_q];
			out_data_q.char_value  <= tok_chr[idx_q];
			out_data_q.last_of_run <= last;
		end
	end

	a_idx_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> q_valid)
		else $error("token index advanced without a queued word");

	a_marker_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.token_kind != KIND_CHAR) |->
		(out_data_q.char_value == 8'h00))
		else $error("marker token carries a character");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt cleared without reset");

	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(halted_q && !out_valid_q) |=> !out_valid_q)
		else $error("token produced after halt");

endmodule

FILE: rtl/core/csv_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_stream_tokenizer
// Path: an accepted byte is written into the queue; the parser then loads
// its tokens into the output register one at a time.
// Throughput: one byte per cycle while the queue is not full; a byte holds
// the parser until its tokens (up to 4) have all been drained.
// Reset: arst_n clears mark check, parse state, halt and the queue; separator = ','.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer #(
	parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// byte input
	input  logic              in_valid,
	output logic              in_ready,
	input  cst_pkg::cst_in_t  in_data,
	// token output
	output logic              out_valid,
	input  logic              out_ready,
	output cst_pkg::cst_out_t out_data,
	// separator register write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);
	import cst_pkg::*;

	localparam int CmdW = $bits(cst_cmd_t);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_valid;
	cst_cmd_t        q_wdata;
	logic [CmdW-1:0] q_rdata;
	cst_cmd_t        q_head;

	// Front: match the byte-order mark, hold the separator, class each byte
	// and pack the ops it causes (mark replay, the byte, end of data) into
	// one queue word. Intake stalls only when the queue is full.
	cst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.q_full    (q_full)
	);

	// Queue: decouple intake from token drain so either side can stall.
	cst_queue #(
		.Width (CmdW),
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_wdata),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_rdata)
	);

	assign q_head = cst_cmd_t'(q_rdata);

	// Back: run the word on the parse state, drain its tokens through the output
	// register one per cycle unless out_ready stalls, and commit the state on the last one.
	cst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: tb/csv_stream_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_tb
// Self-checking bench for the CSV tokenizer. A model of the parser in this
// file predicts the tokens of every accepted byte. Stimulus opens with an
// optional byte-order mark, walks a short directed table, then runs random
// text under several field separators, and finally ends the data and checks
// that the halted block stays silent.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer_tb;
	import cst_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_WORDS  = 18;
	localparam int SETTLE       = 12;

	// One row of the directed table. With typed set, the token is spelled out
	// here (emits low means no token at all); otherwise the model decides.
	typedef struct packed {
		logic [7:0] text;
		logic       typed;
		logic       emits;
		logic [1:0] kind;
		logic [7:0] chr;
	} dir_row_t;

	localparam dir_row_t FREE_ROW = '{8'h00, 1'b0, 1'b0, KIND_CHAR, 8'h00};

	// Parser state as the model keeps it
	typedef struct {
		logic [1:0] bom;
		logic       quoted;
		logic       quote_pend;
		logic       in_field;
		logic       esc_pend;
		logic       skip_rest;
		logic       line_open;
		logic       stopped;
	} scan_state_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	cst_in_t    in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	cst_out_t   out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = 8'h00;

	scan_state_t scan      = '{default: 1'b0};
	logic [7:0]  sep_model = SEP_RESET;
	cst_out_t    run_tokens[$];   // tokens of the byte being modeled
	cst_out_t    tokens_due[$];   // tokens the block still owes us
	dir_row_t    cur_row   = FREE_ROW;
	bit          steady    = 1'b0;
	int          n_bad     = 0;
	int          n_cycles  = 0;

	// Directed table. Starts from whatever the mark prefix left behind; the
	// leading newline clears every flag, so the typed rows after it hold.
	dir_row_t dir_tbl [24] = '{
		'{CH_NL,     1'b0, 1'b0, KIND_CHAR,   8'h00},  // close the prefix line
		'{8'h41,     1'b1, 1'b1, KIND_CHAR,   8'h41},  // plain 'A'
		'{8'h2C,     1'b1, 1'b1, KIND_FIELD,  8'h00},  // default separator
		'{CH_QUOTE,  1'b1, 1'b0, KIND_CHAR,   8'h00},  // open quoting
		'{8'h2C,     1'b0, 1'b0, KIND_CHAR,   8'h00},  // separator inside quotes
		'{CH_QUOTE,  1'b0, 1'b0, KIND_CHAR,   8'h00},
		'{CH_QUOTE,  1'b0, 1'b0, KIND_CHAR,   8'h00},  // doubled quote
		'{CH_QUOTE,  1'b0, 1'b0, KIND_CHAR,   8'h00},
		'{8'h78,     1'b0, 1'b0, KIND_CHAR,   8'h00},  // closes quoting
		'{CH_BSLASH, 1'b1, 1'b0, KIND_CHAR,   8'h00},
		'{8'h74,     1'b0, 1'b0, KIND_CHAR,   8'h00},  // escaped tab
		'{CH_BSLASH, 1'b0, 1'b0, KIND_CHAR,   8'h00},
		'{8'h71,     1'b0, 1'b0, KIND_CHAR,   8'h00},  // unknown escape, dropped
		'{CH_BSLASH, 1'b0, 1'b0, KIND_CHAR,   8'h00},
		'{8'h2C,     1'b0, 1'b0, KIND_CHAR,   8'h00},  // separator still ends a field after a backslash
		'{CH_BSLASH, 1'b0, 1'b0, KIND_CHAR,   8'h00},
		'{CH_BSLASH, 1'b0, 1'b0, KIND_CHAR,   8'h00},  // escaped backslash
		'{CH_CR,     1'b1, 1'b1, KIND_RECORD, 8'h00},  // CR ends the record
		'{8'h7A,     1'b1, 1'b0, KIND_CHAR,   8'h00},  // rest of line ignored
		'{CH_NL,     1'b1, 1'b0, KIND_CHAR,   8'h00},  // skipped line, no token
		'{CH_NL,     1'b1, 1'b1, KIND_RECORD, 8'h00},  // empty line
		'{8'hFF,     1'b1, 1'b1, KIND_CHAR,   8'hFF},  // top byte value
		'{CH_QUOTE,  1'b0, 1'b0, KIND_CHAR,   8'h00},  // quote mid-field is data
		'{CH_NL,     1'b1, 1'b1, KIND_RECORD, 8'h00}
	};

	// Separator for each random phase; the extremes are in here, along with
	// the values that collide with quote, CR, newline and the terminator.
	logic [7:0] phase_sep [7] = '{8'hFF, CH_QUOTE, CH_CR, CH_NL, CH_NUL, 8'h3B, SEP_RESET};

	csv_stream_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	// Queue one token; a byte never yields more than four.
	function automatic void put_token(input logic [1:0] kind, input logic [7:0] ch);
		cst_out_t tok;
		tok.token_kind  = kind;
		tok.char_value  = (kind == KIND_CHAR) ? ch : 8'h00;
		tok.last_of_run = 1'b0;
		if (run_tokens.size() < 4) begin
			run_tokens = {run_tokens, tok};
		end
	endfunction

	function automatic void close_record();
		put_token(KIND_RECORD, 8'h00);
		scan.in_field   = 1'b0;
		scan.esc_pend   = 1'b0;
		scan.quoted     = 1'b0;
		scan.quote_pend = 1'b0;
	endfunction

	// Add a raw character to the field, decoding a pending backslash.
	function automatic void append_char(input logic [7:0] c);
		int d;
		d = -1;
		scan.in_field = 1'b1;
		if (scan.esc_pend) begin
			scan.esc_pend = 1'b0;
			case (c)
				"a":  d = 7;
				"b":  d = 8;
				"f":  d = 12;
				"n":  d = 10;
				"r":  d = 13;
				"t":  d = 9;
				"v":  d = 11;
				"\\": d = 92;
				default: d = -1;
			endcase
			if (d >= 0)
				put_token(KIND_CHAR, d[7:0]);
		end else if (c == CH_BSLASH) begin
			scan.esc_pend = 1'b1;
		end else begin
			put_token(KIND_CHAR, c);
		end
	endfunction

	// One nonzero byte past the mark check
	function automatic void parse_byte(input logic [7:0] b);
		if (b == CH_NL) begin
			if (!scan.skip_rest)
				close_record();
			scan.in_field   = 1'b0;
			scan.esc_pend   = 1'b0;
			scan.quoted     = 1'b0;
			scan.quote_pend = 1'b0;
			scan.skip_rest  = 1'b0;
			scan.line_open  = 1'b0;
			return;
		end
		scan.line_open = 1'b1;
		if (scan.skip_rest)
			return;
		if (scan.quote_pend) begin
			scan.quote_pend = 1'b0;
			if (b == CH_QUOTE) begin
				append_char(b);
				return;
			end
			scan.quoted = 1'b0;
		end
		if (!scan.quoted && !scan.in_field && b == CH_QUOTE) begin
			scan.quoted = 1'b1;
		end else if (scan.quoted && b == CH_QUOTE) begin
			scan.quote_pend = 1'b1;
		end else if (!scan.quoted && b == sep_model) begin
			put_token(KIND_FIELD, 8'h00);
			scan.in_field = 1'b0;
			scan.esc_pend = 1'b0;
		end else if (!scan.quoted && b == CH_CR) begin
			close_record();
			scan.skip_rest = 1'b1;
		end else begin
			append_char(b);
		end
	endfunction

	// Hand a half-matched mark back to the parser as data.
	function automatic void replay_mark();
		if (scan.bom == 2'd1 || scan.bom == 2'd2)
			parse_byte(BOM0);
		if (scan.bom == 2'd2)
			parse_byte(BOM1);
		scan.bom = 2'd3;
	endfunction

	function automatic void close_data();
		if (scan.line_open && !scan.skip_rest)
			close_record();
		scan.stopped = 1'b1;
	endfunction

	// Full effect of one accepted word; tokens land in run_tokens.
	function automatic void tokenize_byte(input cst_in_t w);
		logic hit;
		run_tokens.delete();
		if (scan.stopped)
			return;
		hit = (scan.bom == 2'd0 && w.data_byte == BOM0) ||
		      (scan.bom == 2'd1 && w.data_byte == BOM1) ||
		      (scan.bom == 2'd2 && w.data_byte == BOM2);
		if (hit) begin
			scan.bom = scan.bom + 2'd1;
			if (w.end_of_data) begin
				replay_mark();
				close_data();
			end
		end else begin
			replay_mark();
			if (w.data_byte == CH_NUL) begin
				close_data();
			end else begin
				parse_byte(w.data_byte);
				if (w.end_of_data)
					close_data();
			end
		end
		if (run_tokens.size() > 0)
			run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge, before the block's
	// own updates of that edge land.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cst_out_t want;
		cst_out_t typed_tok;
		if (arst_n) begin
			// Track separator writes so the model splits on the same byte.
			if (cfg_valid && cfg_ready)
				sep_model = cfg_data;

			// Accepted word: advance the model, then queue what is owed. Typed
			// table rows override the model's tokens, the model still advances.
			if (in_valid && in_ready) begin
				tokenize_byte(in_data);
				if (cur_row.typed) begin
					if (cur_row.emits) begin
						typed_tok.token_kind  = cur_row.kind;
						typed_tok.char_value  = cur_row.chr;
						typed_tok.last_of_run = 1'b1;
						tokens_due = {tokens_due, typed_tok};
					end
				end else begin
					tokens_due = {tokens_due, run_tokens};
				end
			end

			// Accepted token: compare field by field with the oldest one owed.
			if (out_valid && out_ready) begin
				if (tokens_due.size() == 0) begin
					n_bad++;
					$display("%0t: unexpected token: expected none, %s %0d %02h %0d",
						$time, "got kind/char/last", out_data.token_kind,
						out_data.char_value, out_data.last_of_run);
				end else begin
					want = tokens_due.pop_front();
					if (out_data.token_kind !== want.token_kind ||
					    out_data.char_value !== want.char_value ||
					    out_data.last_of_run !== want.last_of_run) begin
						n_bad++;
						$display("%0t: token mismatch: expected kind %0d char %02h last %0d,",
							$time, want.token_kind, want.char_value, want.last_of_run);
						$display("%0t:   got kind %0d char %02h last %0d",
							$time, out_data.token_kind, out_data.char_value,
							out_data.last_of_run);
					end
				end
			end
		end

		// Watchdog; stays the last statement of this block.
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d tokens outstanding", $time, tokens_due.size());
			$display("csv_stream_tokenizer test failed");
			$finish;
		end
	end

	// Output side: stall at random with odds of about 29 in a hundred, never while steady.
	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 29);
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offer one word and hold it until taken. Entered and left at a falling
	// edge; idle gaps drop valid, otherwise valid stays up into the next word.
	task automatic push_word(input logic [7:0] b, input logic eod, input dir_row_t row);
		while (!steady && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cur_row  = row;
		in_data  <= '{data_byte: b, end_of_data: eod};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid so the last word is not taken again, then write the
	// separator once the block has drained. A byte that yields no token can
	// still be in flight, so also let the pipe settle for SETTLE first.
	task automatic write_separator(input logic [7:0] v);
		in_valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random CSV-ish text: mostly ordinary characters, with separators,
	// quotes, escapes and line ends mixed in often enough to hit every rule.
	// Zero never appears here, since it would end the data early.
	function automatic logic [7:0] text_byte();
		int r;
		logic [7:0] b;
		r = int'($urandom_range(99));
		if (r < 40) begin
			b = 8'($urandom_range(8'h7E, 8'h20));
		end else if (r < 52) begin
			b = (sep_model == CH_NUL) ? SEP_RESET : sep_model;
		end else if (r < 62) begin
			b = CH_QUOTE;
		end else if (r < 70) begin
			b = CH_BSLASH;
		end else if (r < 80) begin
			case ($urandom_range(7))
				0: b = "a";
				1: b = "b";
				2: b = "f";
				3: b = "n";
				4: b = "r";
				5: b = "t";
				6: b = "v";
				default: b = CH_BSLASH;
			endcase
		end else if (r < 87) begin
			b = CH_NL;
		end else if (r < 91) begin
			b = CH_CR;
		end else begin
			b = 8'($urandom_range(255, 1));
		end
		return b;
	endfunction

	initial begin
		int mode;
		int ending;
		logic [7:0] sep;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Byte-order mark at the very start: whole, two bytes, one byte, or
		// none. A partial mark is replayed as data ahead of the next byte.
		mode = int'($urandom_range(3));
		if (mode <= 2)
			push_word(BOM0, 1'b0, FREE_ROW);
		if (mode <= 1)
			push_word(BOM1, 1'b0, FREE_ROW);
		if (mode == 0)
			push_word(BOM2, 1'b0, FREE_ROW);
		else if (mode <= 2)
			push_word(8'($urandom_range(255, 1)), 1'b0, FREE_ROW);

		// Directed table under the reset separator
		foreach (dir_tbl[i])
			push_word(dir_tbl[i].text, 1'b0, dir_tbl[i]);

		// Random phases, one separator each; phase 2 runs with no idling.
		for (int p = 0; p < 7; p++) begin
			sep = (p == 5) ? 8'($urandom_range(255, 1)) : phase_sep[p];
			write_separator(sep);
			steady = (p == 2);
			repeat (PHASE_WORDS)
				push_word(text_byte(), 1'b0, FREE_ROW);
			steady = 1'b0;
		end

		// End the data one of four ways, then poke the halted block.
		ending = int'($urandom_range(3));
		case (ending)
			0: push_word(CH_NUL, 1'b0, FREE_ROW);
			1: push_word(text_byte(), 1'b1, FREE_ROW);
			2: push_word(CH_NUL, 1'b1, FREE_ROW);
			default: push_word(CH_NL, 1'b1, FREE_ROW);
		endcase
		push_word(8'($urandom_range(255)), 1'b1, FREE_ROW);
		repeat (2)
			push_word(8'($urandom_range(255)), 1'($urandom_range(1)), FREE_ROW);
		in_valid <= 1'b0;

		// Drain, then let the pipe settle so stray tokens get caught.
		while (tokens_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		if (n_bad == 0) begin
			$display("csv_stream_tokenizer test passed");
		end else begin
			$display("csv_stream_tokenizer test failed");
		end
		$finish;
	end

endmodule

FILE: csv_stream_tokenizer.f
rtl/core/cst_pkg.sv
rtl/core/cst_front.sv
rtl/core/cst_queue.sv
rtl/core/cst_back.sv
rtl/core/csv_stream_tokenizer.sv
tb/csv_stream_tokenizer_tb.sv
